/* sv/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Types and character constants shared by the serial line editor receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int unsigned OUT_LIMIT_W = 5;
  localparam logic [OUT_LIMIT_W-1:0] OUT_LIMIT_RESET = 5'd16;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_DEL      = 8'h7F;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  typedef enum logic [1:0] {
    ESC_OFF     = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_BRACKET = 2'd2
  } esc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ECHO,
    S_ERASE,
    S_RC_RD,
    S_RC_EMIT,
    S_EOL_RD,
    S_EOL_WR,
    S_CR,
    S_LF,
    S_TK_RD,
    S_TK_EMIT,
    S_NONE
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       line_done;
    logic       overflow_seen;
    logic [3:0] length;
  } res_t;

endpackage

`default_nettype wire

/* sv/sle_if.sv */
// ----------------------------------------------------------------------------
// sle_req_if / sle_rsp_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface sle_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;
  logic       line_done;
  logic       overflow_seen;
  logic [3:0] length;

  modport source (output valid, output kind, output data, output last,
                  output line_done, output overflow_seen, output length,
                  input ready);
  modport sink (input valid, input kind, input data, input last,
                input line_done, input overflow_seen, input length,
                output ready);
endinterface

`default_nettype wire

/* sv/sle_ram.sv */
// ----------------------------------------------------------------------------
// sle_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/sle_seq.sv */
// ----------------------------------------------------------------------------
// sle_seq
// Line editor sequencer: slot and recall memories, editing state and the
// result word generator, one result word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_seq
  import sle_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  sle_req_if.sink                     req,
  input  wire logic [OUT_LIMIT_W-1:0] out_limit,
  output logic                        emit_valid,
  input  wire logic                   emit_ok,
  output res_t                        emit_res
);

  localparam int unsigned LW  = $clog2(LINE_BYTES);
  localparam int unsigned SAW = $clog2(2 * LINE_BYTES);

  state_t        state, state_next;
  esc_t          esc, esc_next;
  logic [LW-1:0] slot_length [2];
  logic [LW-1:0] slot_length_next [2];
  logic          slot_complete [2];
  logic          slot_complete_next [2];
  logic          fill_index, fill_index_next;
  logic          ready_index, ready_index_next;
  logic          overflow_flag, overflow_flag_next;
  logic          saw_return, saw_return_next;
  logic [LW-1:0] recall_length, recall_length_next;
  logic [LW-1:0] idx, idx_next;
  logic [LW-1:0] cnt_n, cnt_n_next;
  logic          cur, cur_next;
  logic [1:0]    step, step_next;
  logic          rc_mode, rc_mode_next;
  logic          ovf_r, ovf_r_next;
  logic [7:0]    byte_r, byte_r_next;

  logic           slot_we;
  logic [SAW-1:0] slot_waddr;
  logic [7:0]     slot_wdata;
  logic [SAW-1:0] slot_raddr;
  logic [7:0]     slot_rdata;
  logic           rec_we;
  logic [LW-1:0]  rec_waddr;
  logic [7:0]     rec_wdata;
  logic [7:0]     rec_rdata;

  logic                   in_fire;
  logic                   f;
  logic [LW-1:0]          lenf;
  logic [7:0]             c;
  logic                   idx_last;
  logic [OUT_LIMIT_W-1:0] lim;
  logic                   tk_found;
  logic                   tk_sel;
  logic [LW-1:0]          tk_n;

  function automatic logic [SAW-1:0] slot_addr(input logic s, input logic [LW-1:0] i);
    slot_addr = s ? (SAW'(LINE_BYTES) + SAW'(i)) : SAW'(i);
  endfunction

  sle_ram #(.WIDTH(8), .DEPTH(2 * LINE_BYTES)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  sle_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_recall_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (idx),
    .rdata (rec_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign f         = fill_index;
  assign lenf      = slot_length[fill_index];
  assign c         = req.rx_byte;
  assign idx_last  = (({1'b0, idx} + (LW + 1)'(1)) == {1'b0, cnt_n});
  assign lim       = (out_limit == '0) ? '0 : out_limit - OUT_LIMIT_W'(1);
  assign slot_raddr = slot_addr(cur, idx);

  // take slot choice
  always_comb begin
    tk_found = 1'b0;
    tk_sel   = ready_index;
    if (slot_complete[ready_index]) begin
      tk_found = 1'b1;
    end else if (slot_complete[~fill_index]) begin
      tk_found = 1'b1;
      tk_sel   = ~fill_index;
    end
    tk_n = slot_length[tk_sel];
    if (OUT_LIMIT_W'(slot_length[tk_sel]) > lim) begin
      tk_n = LW'(lim);
    end
  end

  always_comb begin
    state_next         = state;
    esc_next           = esc;
    slot_length_next   = slot_length;
    slot_complete_next = slot_complete;
    fill_index_next    = fill_index;
    ready_index_next   = ready_index;
    overflow_flag_next = overflow_flag;
    saw_return_next    = saw_return;
    recall_length_next = recall_length;
    idx_next           = idx;
    cnt_n_next         = cnt_n;
    cur_next           = cur;
    step_next          = step;
    rc_mode_next       = rc_mode;
    ovf_r_next         = ovf_r;
    byte_r_next        = byte_r;
    emit_valid         = 1'b0;
    emit_res           = '0;
    slot_we            = 1'b0;
    slot_waddr         = slot_addr(cur, idx);
    slot_wdata         = rec_rdata;
    rec_we             = 1'b0;
    rec_waddr          = idx;
    rec_wdata          = slot_rdata;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (req.command) begin
            ovf_r_next         = overflow_flag;
            overflow_flag_next = 1'b0;
            if (!tk_found) begin
              state_next = S_NONE;
            end else begin
              slot_length_next[tk_sel]   = '0;
              slot_complete_next[tk_sel] = 1'b0;
              cur_next                   = tk_sel;
              idx_next                   = '0;
              cnt_n_next                 = tk_n;
              state_next = (tk_n == '0) ? S_NONE : S_TK_RD;
            end
          end else begin
            case (esc)
              ESC_SEEN: begin
                esc_next = (c == CH_LBRACKET) ? ESC_BRACKET : ESC_OFF;
              end
              ESC_BRACKET: begin
                esc_next = ESC_OFF;
                if (c == CH_UPPER_A && recall_length != '0 && !slot_complete[f]) begin
                  cur_next     = f;
                  cnt_n_next   = recall_length;
                  idx_next     = '0;
                  rc_mode_next = 1'b1;
                  step_next    = '0;
                  if (lenf != '0) begin
                    slot_length_next[f] = lenf - LW'(1);
                    state_next          = S_ERASE;
                  end else begin
                    state_next = S_RC_RD;
                  end
                end
              end
              default: begin
                if (c == CH_ESC) begin
                  esc_next = ESC_SEEN;
                end else begin
                  esc_next = ESC_OFF;
                  if (c == CH_LF && saw_return) begin
                    saw_return_next = 1'b0;
                  end else begin
                    saw_return_next = (c == CH_CR);
                    if (c == CH_CR || c == CH_LF) begin
                      cur_next                = f;
                      idx_next                = '0;
                      cnt_n_next              = lenf;
                      recall_length_next      = lenf;
                      slot_complete_next[f]   = 1'b1;
                      ready_index_next        = f;
                      fill_index_next         = ~f;
                      slot_length_next[~f]    = '0;
                      slot_complete_next[~f]  = 1'b0;
                      state_next = (lenf != '0) ? S_EOL_RD : S_CR;
                    end else if (c == CH_BS || c == CH_DEL) begin
                      if (!slot_complete[f] && lenf != '0) begin
                        slot_length_next[f] = lenf - LW'(1);
                        step_next           = '0;
                        rc_mode_next        = 1'b0;
                        state_next          = S_ERASE;
                      end
                    end else if (c >= CH_SPACE && c <= CH_TILDE) begin
                      byte_r_next = c;
                      state_next  = S_ECHO;
                      if (slot_complete[f] || lenf >= LW'(LINE_BYTES - 1)) begin
                        overflow_flag_next = 1'b1;
                      end else begin
                        slot_we             = 1'b1;
                        slot_waddr          = slot_addr(f, lenf);
                        slot_wdata          = c;
                        slot_length_next[f] = lenf + LW'(1);
                      end
                    end
                  end
                end
              end
            endcase
          end
        end
      end
      S_ECHO: begin
        emit_valid     = 1'b1;
        emit_res.kind  = KIND_ECHO;
        emit_res.data  = byte_r;
        emit_res.last  = 1'b1;
        if (emit_ok) begin
          state_next = S_IDLE;
        end
      end
      S_ERASE: begin
        emit_valid    = 1'b1;
        emit_res.kind = KIND_ECHO;
        emit_res.data = (step == 2'd1) ? CH_SPACE : CH_BS;
        emit_res.last = (step == 2'd2) && !rc_mode;
        if (emit_ok) begin
          if (step != 2'd2) begin
            step_next = step + 2'd1;
          end else if (!rc_mode) begin
            state_next = S_IDLE;
          end else if (slot_length[cur] != '0) begin
            slot_length_next[cur] = slot_length[cur] - LW'(1);
            step_next             = '0;
          end else begin
            state_next = S_RC_RD;
          end
        end
      end
      S_RC_RD: begin
        state_next = S_RC_EMIT;
      end
      S_RC_EMIT: begin
        emit_valid    = 1'b1;
        emit_res.kind = KIND_ECHO;
        emit_res.data = rec_rdata;
        emit_res.last = idx_last;
        if (emit_ok) begin
          slot_we               = 1'b1;
          slot_length_next[cur] = idx + LW'(1);
          idx_next              = idx + LW'(1);
          state_next            = idx_last ? S_IDLE : S_RC_RD;
        end
      end
      S_EOL_RD: begin
        state_next = S_EOL_WR;
      end
      S_EOL_WR: begin
        rec_we     = 1'b1;
        idx_next   = idx + LW'(1);
        state_next = idx_last ? S_CR : S_EOL_RD;
      end
      S_CR: begin
        emit_valid         = 1'b1;
        emit_res.kind      = KIND_ECHO;
        emit_res.data      = CH_CR;
        emit_res.line_done = 1'b1;
        if (emit_ok) begin
          state_next = S_LF;
        end
      end
      S_LF: begin
        emit_valid         = 1'b1;
        emit_res.kind      = KIND_ECHO;
        emit_res.data      = CH_LF;
        emit_res.line_done = 1'b1;
        emit_res.last      = 1'b1;
        if (emit_ok) begin
          state_next = S_IDLE;
        end
      end
      S_TK_RD: begin
        state_next = S_TK_EMIT;
      end
      S_TK_EMIT: begin
        emit_valid             = 1'b1;
        emit_res.kind          = KIND_CMD;
        emit_res.data          = slot_rdata;
        emit_res.overflow_seen = ovf_r;
        emit_res.length        = 4'(cnt_n);
        emit_res.last          = idx_last;
        if (emit_ok) begin
          idx_next   = idx + LW'(1);
          state_next = idx_last ? S_IDLE : S_TK_RD;
        end
      end
      S_NONE: begin
        emit_valid             = 1'b1;
        emit_res.kind          = KIND_NONE;
        emit_res.overflow_seen = ovf_r;
        emit_res.last          = 1'b1;
        if (emit_ok) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      esc           <= ESC_OFF;
      slot_length   <= '{default: '0};
      slot_complete <= '{default: 1'b0};
      fill_index    <= 1'b0;
      ready_index   <= 1'b0;
      overflow_flag <= 1'b0;
      saw_return    <= 1'b0;
      recall_length <= '0;
      idx           <= '0;
      cnt_n         <= '0;
      cur           <= 1'b0;
      step          <= '0;
      rc_mode       <= 1'b0;
      ovf_r         <= 1'b0;
    end else begin
      state         <= state_next;
      esc           <= esc_next;
      slot_length   <= slot_length_next;
      slot_complete <= slot_complete_next;
      fill_index    <= fill_index_next;
      ready_index   <= ready_index_next;
      overflow_flag <= overflow_flag_next;
      saw_return    <= saw_return_next;
      recall_length <= recall_length_next;
      idx           <= idx_next;
      cnt_n         <= cnt_n_next;
      cur           <= cur_next;
      step          <= step_next;
      rc_mode       <= rc_mode_next;
      ovf_r         <= ovf_r_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_r_next;
  end

  a_one_complete: assert property (@(posedge clk) disable iff (rst)
    !(slot_complete[0] && slot_complete[1]))
    else $error("both line slots complete");

  a_fill_open: assert property (@(posedge clk) disable iff (rst)
    !slot_complete[fill_index])
    else $error("fill slot marked complete");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit_valid && emit_ok && emit_res.last |=> state == S_IDLE)
    else $error("sequencer busy after last word");

  a_take_clears_ovf: assert property (@(posedge clk) disable iff (rst)
    in_fire && req.command |=> !overflow_flag)
    else $error("overflow flag survived a take");

  a_recall_len: assert property (@(posedge clk) disable iff (rst)
    recall_length <= LW'(LINE_BYTES - 1))
    else $error("recall copy longer than a line");

endmodule

`default_nettype wire

/* sv/serial_line_editor_receiver.sv */
// ----------------------------------------------------------------------------
// serial_line_editor_receiver
// Terminal line editor with echo, two ping-pong line slots and line recall.
// ----------------------------------------------------------------------------
// req carries one word per received serial byte (command 0) or per take
// request (command 1); rsp carries echo bytes, command characters and
// "no command" words, with last set on the final word of each request.
// out_limit is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while idle, which the block itself does not enforce. The sequencer
// handles one request at a time; req.ready is high only while it is idle. A
// printable byte passes through S_ECHO into the output register. Backspace
// gives three words (BS, space, BS); end of line copies an n byte line into
// the recall memory, then emits CR LF. A take streams n characters through
// the slot memory read port; a recall erases each byte with three words,
// then replays the recalled bytes. A stalled rsp holds the sequencer at its
// current word; nothing is dropped. Reset empties both slots and the recall
// copy, clears the overflow flag and escape state and sets out_limit to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_editor_receiver
  import sle_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [OUT_LIMIT_W-1:0] cfg_wr_data,
  sle_req_if.sink                     req,
  sle_rsp_if.source                   rsp
);

  logic [OUT_LIMIT_W-1:0] out_limit;
  logic                   emit_valid;
  logic                   emit_ok;
  res_t                   emit_res;
  logic                   out_valid;
  res_t                   out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= OUT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      out_limit <= cfg_wr_data;
    end
  end

  sle_seq #(.LINE_BYTES(LINE_BYTES)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .out_limit  (out_limit),
    .emit_valid (emit_valid),
    .emit_ok    (emit_ok),
    .emit_res   (emit_res)
  );

  // output word register
  assign emit_ok = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ok) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ok) begin
      out_res <= emit_res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.kind          = out_res.kind;
  assign rsp.data          = out_res.data;
  assign rsp.last          = out_res.last;
  assign rsp.line_done     = out_res.line_done;
  assign rsp.overflow_seen = out_res.overflow_seen;
  assign rsp.length        = out_res.length;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Randomized check of the serial line editor receiver. Received bytes and
// take requests go in through the req channel with random gaps. A line
// editor predictor works out the echo, command and empty-take words that
// each accepted request should cause. Words arriving on the rsp channel,
// which stalls at random, are compared field by field against the oldest
// predicted word. out_limit is rewritten while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sle_pkg::*;

  localparam int unsigned LINE_BYTES    = 16;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned WATCHDOG_MAX  = 4000;
  localparam int unsigned RANDOM_WORDS  = 170;
  localparam logic        CMD_RX        = 1'b0;
  localparam logic        CMD_TAKE      = 1'b1;

  typedef enum logic [1:0] {
    ACT_WORD,
    ACT_DRAIN,
    ACT_CFG
  } act_t;

  typedef struct {
    act_t                   act;
    logic                   command;
    logic [7:0]             rx_byte;
    logic [OUT_LIMIT_W-1:0] limit;
    bit                     calm;
  } typed_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [OUT_LIMIT_W-1:0] cfg_wr_data;

  sle_req_if req_ch ();
  sle_rsp_if rsp_ch ();

  serial_line_editor_receiver #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  // line editor image
  bit   [7:0]             slot_text [2*LINE_BYTES];
  bit   [4:0]             slot_len [2];
  bit                     slot_done [2];
  bit                     fill_idx;
  bit                     ready_idx;
  bit                     ovf_flag;
  bit                     saw_cr;
  bit   [7:0]             recall_text [LINE_BYTES];
  bit   [4:0]             recall_len;
  esc_t                   esc;
  logic [OUT_LIMIT_W-1:0] out_limit;

  res_t        line_out_q[$];
  typed_t      typed_q[$];
  int unsigned queued_words;
  int unsigned noise_words;
  int unsigned errors;
  int unsigned quiet_cnt;
  int unsigned idle_cycles;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          calm_now;
  logic        req_fire;
  logic        rsp_fire;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void emit(logic [1:0] k, logic [7:0] d, logic done, logic ovf,
                               logic [3:0] len);
    res_t w;
    w.kind          = k;
    w.data          = d;
    w.last          = 1'b0;
    w.line_done     = done;
    w.overflow_seen = ovf;
    w.length        = len;
    line_out_q.push_back(w);
  endfunction

  function automatic void emit_erase();
    emit(KIND_ECHO, CH_BS, 1'b0, 1'b0, 4'd0);
    emit(KIND_ECHO, CH_SPACE, 1'b0, 1'b0, 4'd0);
    emit(KIND_ECHO, CH_BS, 1'b0, 1'b0, 4'd0);
  endfunction

  task automatic edit_line(logic cmd, logic [7:0] c);
    int unsigned base;
    int unsigned n;
    int unsigned lim;
    int unsigned i;
    bit          f;
    bit          idx;
    bit          ovf;
    base = line_out_q.size();
    f    = fill_idx;
    if (cmd == CMD_TAKE) begin
      ovf      = ovf_flag;
      ovf_flag = 1'b0;
      idx      = ready_idx;
      if (!slot_done[idx]) idx = ~fill_idx;
      if (!slot_done[idx]) begin
        emit(KIND_NONE, 8'd0, 1'b0, ovf, 4'd0);
      end else begin
        n   = slot_len[idx];
        lim = (out_limit > 0) ? out_limit - 1 : 0;
        if (n > lim) n = lim;
        if (n > LINE_BYTES - 1) n = LINE_BYTES - 1;
        slot_len[idx]  = 5'd0;
        slot_done[idx] = 1'b0;
        if (n == 0) begin
          emit(KIND_NONE, 8'd0, 1'b0, ovf, 4'd0);
        end else begin
          for (i = 0; i < n; i++)
            emit(KIND_CMD, slot_text[idx*LINE_BYTES+i], 1'b0, ovf, n[3:0]);
        end
      end
    end else begin
      case (esc)
        ESC_SEEN: esc = (c == CH_LBRACKET) ? ESC_BRACKET : ESC_OFF;
        ESC_BRACKET: begin
          esc = ESC_OFF;
          // up arrow: wipe the line, replay the recalled one
          if (c == CH_UPPER_A && recall_len != 0 && !slot_done[f]) begin
            while (slot_len[f] > 0) begin
              slot_len[f]--;
              emit_erase();
            end
            for (i = 0; i < recall_len && i < LINE_BYTES - 1; i++) begin
              slot_text[f*LINE_BYTES+i] = recall_text[i];
              emit(KIND_ECHO, recall_text[i], 1'b0, 1'b0, 4'd0);
            end
            slot_len[f] = i[4:0];
          end
        end
        default: begin
          if (c == CH_ESC) begin
            esc = ESC_SEEN;
          end else begin
            esc = ESC_OFF;
            if (c == CH_LF && saw_cr) begin
              saw_cr = 1'b0;
            end else begin
              saw_cr = (c == CH_CR);
              if (c == CH_CR || c == CH_LF) begin
                n = slot_len[f];
                if (n > LINE_BYTES - 1) n = LINE_BYTES - 1;
                for (i = 0; i < n; i++) recall_text[i] = slot_text[f*LINE_BYTES+i];
                recall_len          = n[4:0];
                slot_done[f]        = 1'b1;
                ready_idx           = f;
                fill_idx            = ~f;
                slot_len[fill_idx]  = 5'd0;
                slot_done[fill_idx] = 1'b0;
                emit(KIND_ECHO, CH_CR, 1'b1, 1'b0, 4'd0);
                emit(KIND_ECHO, CH_LF, 1'b1, 1'b0, 4'd0);
              end else if (c == CH_BS || c == CH_DEL) begin
                if (!slot_done[f] && slot_len[f] > 0) begin
                  slot_len[f]--;
                  emit_erase();
                end
              end else if (c >= CH_SPACE && c <= CH_TILDE) begin
                emit(KIND_ECHO, c, 1'b0, 1'b0, 4'd0);
                if (slot_done[f] || slot_len[f] >= LINE_BYTES - 1) begin
                  ovf_flag = 1'b1;
                end else begin
                  slot_text[f*LINE_BYTES+slot_len[f]] = c;
                  slot_len[f]++;
                end
              end
            end
          end
        end
      endcase
    end
    if (line_out_q.size() > base) line_out_q[line_out_q.size()-1].last = 1'b1;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic push_word(logic cmd, logic [7:0] b, bit calm);
    typed_t e;
    e.act     = ACT_WORD;
    e.command = cmd;
    e.rx_byte = b;
    e.limit   = '0;
    e.calm    = calm;
    typed_q.push_back(e);
    queued_words++;
  endtask

  task automatic push_ctrl(act_t a, logic [OUT_LIMIT_W-1:0] lim);
    typed_t e;
    e.act     = a;
    e.command = CMD_RX;
    e.rx_byte = 8'd0;
    e.limit   = lim;
    e.calm    = 1'b0;
    typed_q.push_back(e);
  endtask

  task automatic push_text(string s, bit calm);
    for (int i = 0; i < s.len(); i++) push_word(CMD_RX, s[i], calm);
  endtask

  task automatic push_recall(bit calm);
    push_word(CMD_RX, CH_ESC, calm);
    push_word(CMD_RX, CH_LBRACKET, calm);
    push_word(CMD_RX, CH_UPPER_A, calm);
  endtask

  // req side
  always @(negedge clk) begin : drive
    typed_t e;
    logic   nv;
    logic   nwe;
    if (!rst) begin
      nv  = req_ch.valid;
      nwe = 1'b0;
      if (!(req_ch.valid && !req_fire)) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (typed_q.size() > 0) begin
          e = typed_q[0];
          if (e.act == ACT_WORD) begin
            void'(typed_q.pop_front());
            req_ch.command <= e.command;
            req_ch.rx_byte <= e.rx_byte;
            nv       = 1'b1;
            calm_now = e.calm;
            gap_left = pick_gap(e.calm);
          end else if (quiet_cnt >= SETTLE_CYCLES) begin
            void'(typed_q.pop_front());
            if (e.act == ACT_CFG) begin
              cfg_wr_data <= e.limit;
              nwe       = 1'b1;
              out_limit = e.limit;
            end
          end
        end
      end
      req_ch.valid <= nv;
      cfg_wr_en    <= nwe;
    end
  end

  // rsp side back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_fire) stall_left = pick_gap(calm_now);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    res_t want;
    logic rf;
    logic qf;
    if (!rst) begin
      rf = req_ch.valid && req_ch.ready;
      qf = rsp_ch.valid && rsp_ch.ready;
      req_fire <= rf;
      rsp_fire <= qf;
      if (qf) begin
        if (line_out_q.size() == 0) begin
          $error("unexpected word kind %0d data %0d", rsp_ch.kind, rsp_ch.data);
          errors++;
        end else begin
          want = line_out_q.pop_front();
          check_field("kind", want.kind, rsp_ch.kind);
          check_field("data", want.data, rsp_ch.data);
          check_field("last", want.last, rsp_ch.last);
          check_field("line_done", want.line_done, rsp_ch.line_done);
          check_field("overflow_seen", want.overflow_seen, rsp_ch.overflow_seen);
          check_field("length", want.length, rsp_ch.length);
        end
      end
      if (rf) edit_line(req_ch.command, req_ch.rx_byte);
      quiet_cnt   = (rf || line_out_q.size() != 0) ? 0 : quiet_cnt + 1;
      idle_cycles = (rf || qf) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned            r;
    int unsigned            len;
    int unsigned            cfg_i;
    bit                     calm;
    bit                     drained;
    logic [OUT_LIMIT_W-1:0] limits [5];

    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_RX;
    req_ch.rx_byte = 8'd0;
    rsp_ch.ready   = 1'b0;
    req_fire       = 1'b0;
    rsp_fire       = 1'b0;
    esc            = ESC_OFF;
    out_limit      = OUT_LIMIT_RESET;
    calm_now       = 1'b0;
    queued_words   = 0;
    noise_words    = 0;

    // directed opening
    push_word(CMD_TAKE, 8'd0, 1'b0);
    push_word(CMD_RX, 8'h00, 1'b0);
    push_word(CMD_RX, 8'hFF, 1'b0);
    push_word(CMD_RX, CH_BS, 1'b0);
    push_text(" ~ab", 1'b0);
    push_word(CMD_RX, CH_BS, 1'b0);
    push_word(CMD_RX, CH_DEL, 1'b0);
    push_word(CMD_RX, CH_CR, 1'b0);
    push_word(CMD_RX, CH_LF, 1'b0);
    push_word(CMD_TAKE, 8'h5A, 1'b0);
    push_word(CMD_RX, CH_LF, 1'b0);
    push_word(CMD_TAKE, 8'd0, 1'b0);
    push_text("h", 1'b1);
    push_word(CMD_RX, CH_CR, 1'b1);
    push_recall(1'b1);
    push_word(CMD_RX, CH_ESC, 1'b0);
    push_text("X", 1'b0);
    push_recall(1'b0);
    push_word(CMD_RX, CH_CR, 1'b0);
    push_word(CMD_TAKE, 8'd0, 1'b0);

    limits[0] = OUT_LIMIT_RESET;
    limits[1] = 5'd1;
    limits[2] = 5'd0;
    limits[3] = 5'd31;
    limits[4] = 5'($urandom_range(15, 2));
    cfg_i     = 0;
    drained   = 1'b0;

    while (queued_words - noise_words < RANDOM_WORDS) begin
      if (cfg_i < 5 && queued_words - noise_words >= cfg_i * 30) begin
        push_ctrl(ACT_CFG, limits[cfg_i]);
        cfg_i++;
      end
      if (!drained && queued_words - noise_words >= 100) begin
        push_ctrl(ACT_DRAIN, '0);
        drained = 1'b1;
      end
      calm = ($urandom_range(5) == 0);
      r    = $urandom_range(99);
      if (r < 55) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(18, 12) : $urandom_range(8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(7) == 0)
            push_word(CMD_RX, $urandom_range(1) ? CH_BS : CH_DEL, calm);
          else
            push_word(CMD_RX, 8'($urandom_range(CH_TILDE, CH_SPACE)), calm);
        end
        case ($urandom_range(2))
          0: push_word(CMD_RX, CH_CR, calm);
          1: push_word(CMD_RX, CH_LF, calm);
          default: begin
            push_word(CMD_RX, CH_CR, calm);
            push_word(CMD_RX, CH_LF, calm);
          end
        endcase
        if ($urandom_range(9) < 7) push_word(CMD_TAKE, 8'($urandom), calm);
      end else if (r < 67) begin
        if ($urandom_range(1)) push_word(CMD_RX, 8'($urandom_range(CH_TILDE, CH_SPACE)), calm);
        push_recall(calm);
        if ($urandom_range(1)) push_word(CMD_RX, 8'($urandom_range(CH_TILDE, CH_SPACE)), calm);
        push_word(CMD_RX, CH_CR, calm);
        push_word(CMD_TAKE, 8'($urandom), calm);
      end else if (r < 77) begin
        push_word(CMD_TAKE, 8'($urandom), calm);
      end else if (r < 87) begin
        push_word(CMD_RX, 8'($urandom), calm);
        noise_words++;
      end else begin
        push_word(CMD_RX, CH_ESC, calm);
        if ($urandom_range(1)) push_word(CMD_RX, CH_LBRACKET, calm);
        push_word(CMD_RX, 8'($urandom), calm);
      end
    end
    push_word(CMD_TAKE, 8'd0, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (typed_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (line_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (line_out_q.size() != 0) begin
      $error("%0d words never arrived", line_out_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
sv/sle_pkg.sv
sv/sle_if.sv
sv/sle_ram.sv
sv/sle_seq.sv
sv/serial_line_editor_receiver.sv
test/tb_top.sv
